/* hw/rtl/utf8s_pkg.sv */
// Shared types, constants and byte classifiers for the UTF-8 sanitizer.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package utf8s_pkg;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned MaxOut     = 4;
  localparam int unsigned HeldDepth  = 3;

  localparam logic [7:0] ChLf    = 8'h0A;
  localparam logic [7:0] ChCr    = 8'h0D;
  localparam logic [7:0] ChSpace = 8'h20;
  localparam logic [7:0] ChQmark = 8'h3F;
  localparam logic [7:0] ChDel   = 8'h7F;
  localparam logic [7:0] ContLo  = 8'h80;
  localparam logic [7:0] ContHi  = 8'hBF;
  localparam logic [7:0] Lead2Lo = 8'hC2;
  localparam logic [7:0] Lead2Hi = 8'hDF;
  localparam logic [7:0] LeadE0  = 8'hE0;
  localparam logic [7:0] LeadED  = 8'hED;
  localparam logic [7:0] Lead3Hi = 8'hEF;
  localparam logic [7:0] LeadF0  = 8'hF0;
  localparam logic [7:0] LeadF4  = 8'hF4;
  localparam logic [7:0] E0SecLo = 8'hA0;
  localparam logic [7:0] EDSecHi = 8'h9F;
  localparam logic [7:0] F0SecLo = 8'h90;
  localparam logic [7:0] F4SecHi = 8'h8F;

  // Up to four output bytes produced by one input beat.
  typedef struct packed {
    logic [MaxOut-1:0][7:0] bytes;
    logic [2:0]             cnt;
    logic                   last;
  } utf8s_bundle_t;

  typedef struct packed {
    logic full;
    logic empty;
  } utf8s_qstat_t;

  // Sequence length implied by a lead byte, zero when not a valid lead.
  function automatic logic [2:0] lead_length(input logic [7:0] b);
    logic [2:0] len;
    len = 3'd0;
    if (b >= Lead2Lo && b <= Lead2Hi) len = 3'd2;
    else if (b >= LeadE0 && b <= Lead3Hi) len = 3'd3;
    else if (b >= LeadF0 && b <= LeadF4) len = 3'd4;
    return len;
  endfunction

  // Continuation range check; the second byte has narrower ranges after some leads.
  function automatic logic cont_ok(input logic [7:0] lead, input logic [1:0] pos,
                                   input logic [7:0] b);
    logic [7:0] lo;
    logic [7:0] hi;
    lo = ContLo;
    hi = ContHi;
    if (pos == 2'd1) begin
      if (lead == LeadE0) lo = E0SecLo;
      else if (lead == LeadED) hi = EDSecHi;
      else if (lead == LeadF0) lo = F0SecLo;
      else if (lead == LeadF4) hi = F4SecHi;
    end
    return (b >= lo) && (b <= hi);
  endfunction

endpackage

/* hw/rtl/utf8_sanitizer_top.sv */
// Top level of the UTF-8 sanitizer: front end, bundle queue and back end.
// Depends on utf8s_pkg, utf8s_front, utf8s_queue and utf8s_back.
//
//   channel  direction  handshake               payload
//   in       input      in_valid / in_stall     in_byte[7:0], in_stream_last
//   out      output     out_valid / out_stall   out_byte[7:0], out_run_last,
//                                                out_stream_done
//
// The front end takes one input beat per cycle while the queue has room; an input
// producing n result bytes (n is 0..4) is sent as n output beats, so the sustained
// rate is one input per cycle for plain text while out_stall is low.
// The queue holds QUEUE_DEPTH bundles; in_stall rises only when it is full, so
// out_stall never reaches in_stall combinationally.
// Reset is synchronous on rst_n: it clears sequence tracking, queue pointers and
// the output valid; held bytes and payload registers carry no reset.
`timescale 1ns / 1ps

module utf8_sanitizer_top
  import utf8s_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = QueueDepth
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_byte,
  input  logic       in_stream_last,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_byte,
  output logic       out_run_last,
  output logic       out_stream_done
);

  utf8s_bundle_t push_data;
  utf8s_bundle_t head;
  utf8s_qstat_t  q_stat;
  logic          push;
  logic          pop;

  // Classify each byte and gather its results into one bundle.
  utf8s_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_byte        (in_byte),
    .in_stream_last (in_stream_last),
    .q_stat         (q_stat),
    .push           (push),
    .push_data      (push_data)
  );

  // Hold bundles so each side can stall on its own.
  utf8s_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .head      (head),
    .q_stat    (q_stat)
  );

  // Advance through each bundle one output beat at a time.
  utf8s_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .head            (head),
    .q_stat          (q_stat),
    .pop             (pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_byte        (out_byte),
    .out_run_last    (out_run_last),
    .out_stream_done (out_stream_done)
  );

endmodule

/* hw/rtl/utf8s_front.sv */
// Front end: accepts raw bytes, tracks the open UTF-8 sequence and builds output bundles.
// Depends on utf8s_pkg.
`timescale 1ns / 1ps

module utf8s_front
  import utf8s_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    in_byte,
  input  logic          in_stream_last,
  input  utf8s_qstat_t  q_stat,
  output logic          push,
  output utf8s_bundle_t push_data
);

  logic [HeldDepth-1:0][7:0] held_r;
  logic [HeldDepth-1:0][7:0] held_nxt;
  logic [1:0]                held_cnt_r;
  logic [1:0]                held_cnt_nxt;
  logic [2:0]                seq_len_r;
  logic [2:0]                seq_len_nxt;
  utf8s_bundle_t             bnd;
  logic                      accept;
  logic                      done;
  logic [2:0]                len;

  function automatic utf8s_bundle_t add_byte(input utf8s_bundle_t cur, input logic [7:0] b);
    utf8s_bundle_t r;
    r = cur;
    if (cur.cnt < 3'(MaxOut)) begin
      r.bytes[cur.cnt[1:0]] = b;
      r.cnt = cur.cnt + 3'd1;
    end
    return r;
  endfunction

  assign in_stall = q_stat.full;
  assign accept   = in_valid && !q_stat.full;

  always_comb begin
    bnd          = '0;
    held_nxt     = held_r;
    held_cnt_nxt = held_cnt_r;
    seq_len_nxt  = seq_len_r;
    done         = 1'b0;
    len          = lead_length(in_byte);

    if (seq_len_r != 3'd0 && held_cnt_r != 2'd0) begin
      if (cont_ok(held_r[0], held_cnt_r, in_byte)) begin
        if ({1'b0, held_cnt_r} + 3'd1 == seq_len_r) begin
          // sequence complete: release it whole
          for (int i = 0; i < HeldDepth; i++) begin
            if (2'(i) < held_cnt_r) bnd = add_byte(bnd, held_r[i]);
          end
          bnd          = add_byte(bnd, in_byte);
          held_cnt_nxt = 2'd0;
          seq_len_nxt  = 3'd0;
        end else begin
          if (held_cnt_r != 2'd3) held_nxt[held_cnt_r] = in_byte;
          held_cnt_nxt = held_cnt_r + 2'd1;
        end
        done = 1'b1;
      end else begin
        // broken sequence: one '?' per held byte, then retry this byte as a lead
        for (int i = 0; i < HeldDepth; i++) begin
          if (2'(i) < held_cnt_r) bnd = add_byte(bnd, ChQmark);
        end
        held_cnt_nxt = 2'd0;
        seq_len_nxt  = 3'd0;
      end
    end else begin
      held_cnt_nxt = 2'd0;
      seq_len_nxt  = 3'd0;
    end

    if (!done) begin
      if (!in_byte[7]) begin
        if (in_byte == ChLf || in_byte == ChCr) bnd = add_byte(bnd, in_byte);
        else if (in_byte < ChSpace || in_byte == ChDel) bnd = add_byte(bnd, ChSpace);
        else bnd = add_byte(bnd, in_byte);
      end else if (len != 3'd0) begin
        held_nxt[0]  = in_byte;
        held_cnt_nxt = 2'd1;
        seq_len_nxt  = len;
      end else begin
        bnd = add_byte(bnd, ChQmark);
      end
    end

    if (in_stream_last) begin
      // flush whatever is still pending at end of stream
      for (int i = 0; i < HeldDepth; i++) begin
        if (2'(i) < held_cnt_nxt) bnd = add_byte(bnd, ChQmark);
      end
      held_cnt_nxt = 2'd0;
      seq_len_nxt  = 3'd0;
    end
    bnd.last = in_stream_last;
  end

  assign push      = accept && (bnd.cnt != 3'd0);
  assign push_data = bnd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      held_cnt_r <= 2'd0;
      seq_len_r  <= 3'd0;
    end else if (accept) begin
      held_cnt_r <= held_cnt_nxt;
      seq_len_r  <= seq_len_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) held_r <= held_nxt;
  end

endmodule

/* hw/rtl/utf8s_queue.sv */
// Short bundle queue between front end and back end.
// Depends on utf8s_pkg.
`timescale 1ns / 1ps

module utf8s_queue
  import utf8s_pkg::*;
#(
  parameter int unsigned DEPTH = QueueDepth
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          push,
  input  utf8s_bundle_t push_data,
  input  logic          pop,
  output utf8s_bundle_t head,
  output utf8s_qstat_t  q_stat
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  utf8s_bundle_t       entry_r [DEPTH];
  logic [PtrW-1:0]     wr_ptr_r;
  logic [PtrW-1:0]     wr_ptr_nxt;
  logic [PtrW-1:0]     rd_ptr_r;
  logic [PtrW-1:0]     rd_ptr_nxt;
  logic [CntW-1:0]     cnt_r;
  logic [CntW-1:0]     cnt_nxt;
  logic                do_push;
  logic                do_pop;

  assign q_stat.full  = (cnt_r == CntW'(DEPTH));
  assign q_stat.empty = (cnt_r == '0);
  assign do_push      = push && !q_stat.full;
  assign do_pop       = pop && !q_stat.empty;
  assign head         = entry_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + PtrW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + PtrW'(1);
    end
    if (do_push && !do_pop) cnt_nxt = cnt_r + CntW'(1);
    else if (do_pop && !do_push) cnt_nxt = cnt_r - CntW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entry_r[wr_ptr_r] <= push_data;
  end

endmodule

/* hw/rtl/utf8s_back.sv */
// Back end: walks the head bundle one byte per beat into the output register.
// Depends on utf8s_pkg.
`timescale 1ns / 1ps

module utf8s_back
  import utf8s_pkg::*;
(
  input  logic          clk,
  input  logic          rst_n,
  input  utf8s_bundle_t head,
  input  utf8s_qstat_t  q_stat,
  output logic          pop,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    out_byte,
  output logic          out_run_last,
  output logic          out_stream_done
);

  logic [1:0] idx_r;
  logic [1:0] idx_nxt;
  logic       valid_r;
  logic       valid_nxt;
  logic [7:0] byte_r;
  logic       run_last_r;
  logic       done_r;
  logic       load;
  logic       take;
  logic       fin;

  assign load = !valid_r || !out_stall;
  assign take = load && !q_stat.empty;
  assign fin  = ({1'b0, idx_r} + 3'd1 == head.cnt);
  assign pop  = take && fin;

  always_comb begin
    idx_nxt   = idx_r;
    valid_nxt = valid_r;
    if (load) valid_nxt = !q_stat.empty;
    if (take) idx_nxt = fin ? 2'd0 : idx_r + 2'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r   <= 2'd0;
      valid_r <= 1'b0;
    end else begin
      idx_r   <= idx_nxt;
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      byte_r     <= head.bytes[idx_r];
      run_last_r <= fin;
      done_r     <= fin && head.last;
    end
  end

  assign out_valid       = valid_r;
  assign out_byte        = byte_r;
  assign out_run_last    = run_last_r;
  assign out_stream_done = done_r;

endmodule
